// ===== hdl/wial_pkg.sv =====
`timescale 1ns / 1ps
// wial_pkg: shared constants for the 128-bit integer ALU.
// Operation codes and word geometry; no dependencies.
package wial_pkg;

    localparam int WORD_BITS = 128;
    localparam int HALF_BITS = 64;
    localparam int LIMB_BITS = 32;
    localparam int OP_BITS   = 3;
    localparam int AMT_BITS  = 9;

    localparam logic [OP_BITS-1:0] OP_SEXT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_NEG  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_BITS-1:0] OP_SHL  = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SHR  = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SAR  = 3'd7;

endpackage

// ===== hdl/wide_integer_alu_128_unit.sv =====
`timescale 1ns / 1ps
// wide_integer_alu_128_unit: top level of the 128-bit integer ALU.
// Uses wial_pkg, wial_mul and wial_shift.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  command  | start / busy (busy tied 0) | i_operation, i_a_*, i_b_*, i_shift_amount
//  result   | o_result_valid strobe      | o_result_low, o_result_high
//
// One operation enters per cycle; every result leaves with its o_result_valid strobe.
// Latency is set by the multiplier: limb products, column sums and two final adds.
// Add, subtract, negate and shifts finish in two stages and ride the pipe to keep order.
// Synchronous active-low reset clears the valid bits only; no clearing pass.
// Results cannot be stalled, so busy never rises.
module wide_integer_alu_128_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [wial_pkg::OP_BITS-1:0]         i_operation,
    input  logic [wial_pkg::HALF_BITS-1:0]       i_a_low,
    input  logic [wial_pkg::HALF_BITS-1:0]       i_a_high,
    input  logic [wial_pkg::HALF_BITS-1:0]       i_b_low,
    input  logic [wial_pkg::HALF_BITS-1:0]       i_b_high,
    input  logic signed [wial_pkg::AMT_BITS-1:0] i_shift_amount,
    output logic                                 o_result_valid,
    output logic [wial_pkg::HALF_BITS-1:0]       o_result_low,
    output logic [wial_pkg::HALF_BITS-1:0]       o_result_high
);

    logic         accept;
    logic [127:0] a_word;
    logic [127:0] b_word;
    logic [127:0] x_op;
    logic [127:0] y_op;
    logic         cin;
    logic [64:0]  n1_sum_lo;
    logic [63:0]  n2_sum_hi;
    logic [127:0] n2_res;
    logic         n2_shift;
    logic [127:0] shift_result;
    logic [127:0] mul_product;

    logic         r1_valid, r2_valid, r3_valid, r4_valid;
    logic [2:0]   r1_op;
    logic [63:0]  r1_sum_lo;
    logic         r1_carry;
    logic [63:0]  r1_x_hi;
    logic [63:0]  r1_y_hi;
    logic         r2_mul, r3_mul, r4_mul;
    logic [127:0] r2_res, r3_res, r4_res;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign a_word = {i_a_high, i_a_low};
    assign b_word = {i_b_high, i_b_low};

    // sign-extend runs through the adder with a zero second operand
    always_comb begin
        case (i_operation)
            wial_pkg::OP_SEXT: begin
                x_op = {{64{i_a_low[63]}}, i_a_low};
                y_op = '0;
                cin  = 1'b0;
            end
            wial_pkg::OP_NEG: begin
                x_op = '0;
                y_op = ~a_word;
                cin  = 1'b1;
            end
            wial_pkg::OP_ADD: begin
                x_op = a_word;
                y_op = b_word;
                cin  = 1'b0;
            end
            wial_pkg::OP_SUB: begin
                x_op = a_word;
                y_op = ~b_word;
                cin  = 1'b1;
            end
            default: begin
                x_op = a_word;
                y_op = '0;
                cin  = 1'b0;
            end
        endcase
        n1_sum_lo = {1'b0, x_op[63:0]} + {1'b0, y_op[63:0]} + {64'd0, cin};
    end

    wial_mul u_mul (
        .i_clk     (i_clk),
        .i_a       (a_word),
        .i_b       (b_word),
        .o_product (mul_product)
    );

    wial_shift u_shift (
        .i_clk          (i_clk),
        .i_operation    (i_operation),
        .i_a            (a_word),
        .i_shift_amount (i_shift_amount),
        .o_result       (shift_result)
    );

    always_comb begin
        n2_sum_hi = r1_x_hi + r1_y_hi + {63'd0, r1_carry};
        n2_shift  = (r1_op == wial_pkg::OP_SHL) || (r1_op == wial_pkg::OP_SHR)
                 || (r1_op == wial_pkg::OP_SAR);
        n2_res    = n2_shift ? shift_result : {n2_sum_hi, r1_sum_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op     <= i_operation;
        r1_sum_lo <= n1_sum_lo[63:0];
        r1_carry  <= n1_sum_lo[64];
        r1_x_hi   <= x_op[127:64];
        r1_y_hi   <= y_op[127:64];

        r2_mul <= (r1_op == wial_pkg::OP_MUL);
        r2_res <= n2_res;
        r3_mul <= r2_mul;
        r3_res <= r2_res;
        r4_mul <= r3_mul;
        r4_res <= r3_res;
    end

    assign o_result_valid = r4_valid;
    assign o_result_low   = r4_mul ? mul_product[63:0]   : r4_res[63:0];
    assign o_result_high  = r4_mul ? mul_product[127:64] : r4_res[127:64];

endmodule

// ===== hdl/wial_mul.sv =====
`timescale 1ns / 1ps
// wial_mul: four-stage 128x128 multiplier keeping the low 128 bits.
// 32-bit limb products, column sums, two-step final add; uses wial_pkg.
module wial_mul (
    input  logic                          i_clk,
    input  logic [wial_pkg::WORD_BITS-1:0] i_a,
    input  logic [wial_pkg::WORD_BITS-1:0] i_b,
    output logic [wial_pkg::WORD_BITS-1:0] o_product
);

    logic [31:0] a0, a1, a2, a3, b0, b1, b2, b3;
    logic [63:0] n_p00, n_p01, n_p10, n_p02, n_p11, n_p20;
    logic [31:0] n_q03, n_q12, n_q21, n_q30;
    logic [63:0] r_p00, r_p01, r_p10, r_p02, r_p11, r_p20;
    logic [31:0] r_q03, r_q12, r_q21, r_q30;
    logic [63:0] r_c0;
    logic [64:0] r_c1;
    logic [65:0] r_c2;
    logic [31:0] r_c3;
    logic [96:0] r_x;
    logic [63:0] r_y;
    logic [127:0] r_product;

    always_comb begin
        a0 = i_a[31:0];   a1 = i_a[63:32];  a2 = i_a[95:64];  a3 = i_a[127:96];
        b0 = i_b[31:0];   b1 = i_b[63:32];  b2 = i_b[95:64];  b3 = i_b[127:96];
        n_p00 = 64'(a0) * 64'(b0);
        n_p01 = 64'(a0) * 64'(b1);
        n_p10 = 64'(a1) * 64'(b0);
        n_p02 = 64'(a0) * 64'(b2);
        n_p11 = 64'(a1) * 64'(b1);
        n_p20 = 64'(a2) * 64'(b0);
        n_q03 = a0 * b3;
        n_q12 = a1 * b2;
        n_q21 = a2 * b1;
        n_q30 = a3 * b0;
    end

    always_ff @(posedge i_clk) begin
        r_p00 <= n_p00;
        r_p01 <= n_p01;
        r_p10 <= n_p10;
        r_p02 <= n_p02;
        r_p11 <= n_p11;
        r_p20 <= n_p20;
        r_q03 <= n_q03;
        r_q12 <= n_q12;
        r_q21 <= n_q21;
        r_q30 <= n_q30;

        r_c0 <= r_p00;
        r_c1 <= {1'b0, r_p01} + {1'b0, r_p10};
        r_c2 <= {2'b00, r_p02} + {2'b00, r_p11} + {2'b00, r_p20};
        r_c3 <= r_q03 + r_q12 + r_q21 + r_q30;

        r_x <= {33'd0, r_c0} + {r_c1, 32'd0};
        r_y <= r_c2[63:0] + {r_c3, 32'd0};

        r_product <= {31'd0, r_x} + {r_y, 64'd0};
    end

    assign o_product = r_product;

endmodule

// ===== hdl/wial_shift.sv =====
`timescale 1ns / 1ps
// wial_shift: two-step 128-bit shifter, 16-bit steps then 0..15 bits.
// Handles no-shift and saturating counts; uses wial_pkg.
module wial_shift (
    input  logic                                 i_clk,
    input  logic [wial_pkg::OP_BITS-1:0]         i_operation,
    input  logic [wial_pkg::WORD_BITS-1:0]       i_a,
    input  logic signed [wial_pkg::AMT_BITS-1:0] i_shift_amount,
    output logic [wial_pkg::WORD_BITS-1:0]       o_result
);

    logic         left;
    logic         fill;
    logic         no_shift;
    logic         saturate;
    logic [6:0]   amount;
    logic [6:0]   coarse_amt;
    logic [255:0] ext;
    logic [127:0] n_coarse;
    logic [3:0]   n_fine;
    logic [127:0] r_coarse;
    logic [3:0]   r_fine;
    logic         r_fill;
    logic         r_left;
    logic [255:0] fine_ext;

    always_comb begin
        left       = (i_operation == wial_pkg::OP_SHL);
        fill       = (i_operation == wial_pkg::OP_SAR) & i_a[127];
        no_shift   = i_shift_amount[8] || (i_shift_amount == 9'sd0);
        saturate   = !i_shift_amount[8] && i_shift_amount[7];
        amount     = no_shift ? 7'd0 : i_shift_amount[6:0];
        coarse_amt = {amount[6:4], 4'b0000};
        ext        = {{128{fill}}, i_a} >> coarse_amt;
        if (saturate) begin
            n_coarse = {128{fill}};
        end else if (left) begin
            n_coarse = i_a << coarse_amt;
        end else begin
            n_coarse = ext[127:0];
        end
        n_fine = saturate ? 4'd0 : amount[3:0];
    end

    always_ff @(posedge i_clk) begin
        r_coarse <= n_coarse;
        r_fine   <= n_fine;
        r_fill   <= fill;
        r_left   <= left;
    end

    always_comb begin
        fine_ext = {{128{r_fill}}, r_coarse} >> r_fine;
        o_result = r_left ? (r_coarse << r_fine) : fine_ext[127:0];
    end

endmodule

// ===== hdl/wial_checker.sv =====
`timescale 1ns / 1ps
// wial_checker: port-level checks for wide_integer_alu_128_unit, with its bind.
// Uses wial_pkg for operation codes.
module wial_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [wial_pkg::OP_BITS-1:0]         i_operation,
    input logic [wial_pkg::HALF_BITS-1:0]       i_a_low,
    input logic [wial_pkg::HALF_BITS-1:0]       i_a_high,
    input logic [wial_pkg::HALF_BITS-1:0]       i_b_low,
    input logic [wial_pkg::HALF_BITS-1:0]       i_b_high,
    input logic                                 o_result_valid,
    input logic [wial_pkg::HALF_BITS-1:0]       o_result_low,
    input logic [wial_pkg::HALF_BITS-1:0]       o_result_high
);

    logic [127:0] sum_ab;
    logic [127:0] sext_a;

    assign sum_ab = {i_a_high, i_a_low} + {i_b_high, i_b_low};
    assign sext_a = {{64{i_a_low[63]}}, i_a_low};

    a_transfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_result_valid)
        else $error("transfer without result four cycles later");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##4 !o_result_valid)
        else $error("result strobe without a matching transfer");

    a_add_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == wial_pkg::OP_ADD)) |-> ##4
        ({o_result_high, o_result_low} == $past(sum_ab, 4)))
        else $error("add result mismatch");

    a_sext_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == wial_pkg::OP_SEXT)) |-> ##4
        ({o_result_high, o_result_low} == $past(sext_a, 4)))
        else $error("sign-extend result mismatch");

endmodule

bind wide_integer_alu_128_unit wial_checker u_wial_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .i_a_low        (i_a_low),
    .i_a_high       (i_a_high),
    .i_b_low        (i_b_low),
    .i_b_high       (i_b_high),
    .o_result_valid (o_result_valid),
    .o_result_low   (o_result_low),
    .o_result_high  (o_result_high)
);
